/* src/nif_pkg.sv */
package nif_pkg;

  // timing base and frame size
  localparam int TICK_US    = 128;
  localparam int FRAME_BITS = 32;
  localparam int TICKS_W    = 8;
  localparam int TIME_W     = TICKS_W + $clog2(TICK_US + 1);
  localparam int CNT_W      = 6;
  localparam int IDX_W      = $clog2(FRAME_BITS);

  // nominal durations in us
  localparam int unsigned D_LEAD   = 9500;
  localparam int unsigned D_START  = 4500;
  localparam int unsigned D_REPEAT = 2250;
  localparam int unsigned D_SHORT  = 540;
  localparam int unsigned D_LONG   = 1688;

  // acceptance windows, floor(d * 0.7) to floor(d * 1.3)
  localparam int unsigned LEAD_LO   = (D_LEAD * 7) / 10;
  localparam int unsigned LEAD_HI   = (D_LEAD * 13) / 10;
  localparam int unsigned START_LO  = (D_START * 7) / 10;
  localparam int unsigned START_HI  = (D_START * 13) / 10;
  localparam int unsigned REPEAT_LO = (D_REPEAT * 7) / 10;
  localparam int unsigned REPEAT_HI = (D_REPEAT * 13) / 10;
  localparam int unsigned SHORT_LO  = (D_SHORT * 7) / 10;
  localparam int unsigned SHORT_HI  = (D_SHORT * 13) / 10;
  localparam int unsigned LONG_LO   = (D_LONG * 7) / 10;
  localparam int unsigned LONG_HI   = (D_LONG * 13) / 10;

  // item function codes
  localparam logic [1:0] FN_EDGE = 2'd0;
  localparam logic [1:0] FN_OVF  = 2'd1;
  localparam logic [1:0] FN_POLL = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_LO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ML = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_MH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_HI = 3'd4;

  localparam logic [7:0] TIMEOUT_RST = 8'd4;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEAD   = 3'd1,
    PH_LSPACE = 3'd2,
    PH_DATA   = 3'd3,
    PH_FINAL  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_READY     = 2'd0,
    ST_REPEAT    = 2'd1,
    ST_NOT_READY = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         func;
    logic               level;
    logic [TICKS_W-1:0] duration_ticks;
  } item_t;

  typedef struct packed {
    logic       data_ready;
    logic [7:0] address;
    logic [7:0] command;
  } result_t;

  function automatic logic in_window(logic [TIME_W-1:0] t, int unsigned lo, int unsigned hi);
    in_window = (32'(t) >= lo) && (32'(t) <= hi);
  endfunction

endpackage

/* src/nif_in_stage.sv */
module nif_in_stage import nif_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t item_in,
  input  logic  step,
  output logic  held,
  output item_t item
);

  // accept whenever the stage is empty or its beat moves on this cycle
  assign in_ready = !held || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_in;
    end
  end

endmodule

/* src/nif_core.sv */
module nif_core import nif_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 step,
  input  item_t                item,
  output result_t              result
);

  phase_t                phase, phase_next;
  status_t               status, status_next;
  logic [FRAME_BITS-1:0] bit_store, bit_store_next;
  logic [CNT_W-1:0]      bit_count, bit_count_next;
  logic                  repeat_seen, repeat_seen_next;
  logic [7:0]            ovf_count, ovf_count_next;
  logic                  armed, armed_next;
  logic [7:0]            lat_addr, lat_addr_next;
  logic [7:0]            lat_cmd, lat_cmd_next;
  logic                  ready;

  logic [7:0]   timeout;
  logic [255:0] rep_mask;

  logic [TIME_W-1:0] t;
  logic              is_edge, is_ovf, is_poll, high;
  logic              win_lead, win_start, win_rep, win_short, win_long;
  logic [CNT_W-1:0]  cnt_inc;
  logic [7:0]        ovf_inc;
  logic              timeout_hit;
  logic [7:0]        f_addr, f_naddr, f_cmd, f_ncmd;
  logic              frame_ok, blocked;

  // item decode and duration windows
  assign t         = TIME_W'(32'(item.duration_ticks) * TICK_US);
  assign is_edge   = item.func == FN_EDGE;
  assign is_ovf    = item.func == FN_OVF;
  assign is_poll   = item.func == FN_POLL;
  assign high      = item.level;
  assign win_lead  = in_window(t, LEAD_LO, LEAD_HI);
  assign win_start = in_window(t, START_LO, START_HI);
  assign win_rep   = in_window(t, REPEAT_LO, REPEAT_HI);
  assign win_short = in_window(t, SHORT_LO, SHORT_HI);
  assign win_long  = in_window(t, LONG_LO, LONG_HI);

  assign cnt_inc     = bit_count + CNT_W'(1);
  assign ovf_inc     = ovf_count + 8'd1;
  assign timeout_hit = ovf_inc >= timeout;

  // frame check on the stored bits
  assign f_addr   = bit_store[7:0];
  assign f_naddr  = bit_store[15:8];
  assign f_cmd    = bit_store[23:16];
  assign f_ncmd   = bit_store[31:24];
  assign frame_ok = ((f_addr ^ f_naddr) == 8'hFF) && ((f_cmd ^ f_ncmd) == 8'hFF);
  assign blocked  = rep_mask[f_cmd];

  // capture phase transitions
  always_comb begin
    phase_next = phase;
    if (step && is_edge) begin
      case (phase)
        PH_IDLE: begin
          if (!high) phase_next = PH_LEAD;
        end
        PH_LEAD: begin
          phase_next = (high && win_lead) ? PH_LSPACE : PH_IDLE;
        end
        PH_LSPACE: begin
          if (!high && win_start) phase_next = PH_DATA;
          else if (!high && win_rep) phase_next = PH_FINAL;
          else phase_next = PH_IDLE;
        end
        PH_DATA: begin
          if (!high) begin
            if (win_short || win_long) begin
              if (cnt_inc >= CNT_W'(FRAME_BITS)) phase_next = PH_FINAL;
            end else begin
              phase_next = PH_IDLE;
            end
          end
        end
        PH_FINAL: phase_next = PH_IDLE;
        default:  phase_next = PH_IDLE;
      endcase
    end else if (step && is_ovf && armed && timeout_hit) begin
      phase_next = PH_IDLE;
    end
  end

  // frame status, bit gathering, timer and poll answer
  always_comb begin
    status_next      = status;
    bit_store_next   = bit_store;
    bit_count_next   = bit_count;
    repeat_seen_next = repeat_seen;
    ovf_count_next   = ovf_count;
    armed_next       = armed;
    lat_addr_next    = lat_addr;
    lat_cmd_next     = lat_cmd;
    ready            = 1'b0;
    if (step && is_edge) begin
      case (phase)
        PH_IDLE: begin
          if (!high) armed_next = 1'b1;
          else status_next = ST_NOT_READY;
        end
        PH_LEAD: begin
          if (!(high && win_lead)) status_next = ST_NOT_READY;
        end
        PH_LSPACE: begin
          if (!high && win_start) begin
            repeat_seen_next = 1'b0;
            bit_count_next   = '0;
          end else if (!high && win_rep) begin
            repeat_seen_next = 1'b1;
          end else begin
            status_next = ST_NOT_READY;
          end
        end
        PH_DATA: begin
          if (!high) begin
            if (win_short || win_long) begin
              bit_store_next[bit_count[IDX_W-1:0]] = win_long;
              bit_count_next = cnt_inc;
            end else begin
              status_next = ST_NOT_READY;
            end
          end
        end
        PH_FINAL: begin
          if (high && win_short) begin
            if (!repeat_seen) status_next = ST_READY;
            ovf_count_next = '0;
          end else begin
            status_next = ST_NOT_READY;
          end
        end
        default: ;
      endcase
    end else if (step && is_ovf && armed) begin
      if (timeout_hit) begin
        armed_next     = 1'b0;
        status_next    = ST_NOT_READY;
        ovf_count_next = '0;
      end else begin
        ovf_count_next = ovf_inc;
      end
    end else if (step && is_poll) begin
      if (status == ST_READY) begin
        if (frame_ok) begin
          lat_addr_next = f_addr;
          lat_cmd_next  = f_cmd;
          status_next   = blocked ? ST_NOT_READY : ST_REPEAT;
          ready         = 1'b1;
        end else begin
          status_next = ST_NOT_READY;
        end
      end else begin
        ready = status == ST_REPEAT;
      end
    end
  end

  assign result = '{data_ready: ready, address: lat_addr_next, command: lat_cmd_next};

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      status      <= ST_NOT_READY;
      bit_store   <= '0;
      bit_count   <= '0;
      repeat_seen <= 1'b0;
      ovf_count   <= '0;
      armed       <= 1'b0;
      lat_addr    <= '0;
      lat_cmd     <= '0;
    end else begin
      phase       <= phase_next;
      status      <= status_next;
      bit_store   <= bit_store_next;
      bit_count   <= bit_count_next;
      repeat_seen <= repeat_seen_next;
      ovf_count   <= ovf_count_next;
      armed       <= armed_next;
      lat_addr    <= lat_addr_next;
      lat_cmd     <= lat_cmd_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout  <= TIMEOUT_RST;
      rep_mask <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TIMEOUT: timeout          <= cfg_data[7:0];
        REG_MASK_LO: rep_mask[63:0]   <= cfg_data;
        REG_MASK_ML: rep_mask[127:64] <= cfg_data;
        REG_MASK_MH: rep_mask[191:128] <= cfg_data;
        REG_MASK_HI: rep_mask[255:192] <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* src/nif_out_stage.sv */
module nif_out_stage import nif_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  result_t result_in,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result
);

  // room for a new beat when empty or when the held one leaves now
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= result_in;
    end
  end

endmodule

/* src/nec_ir_frame_decoder.sv */
// NEC infrared frame decoder.
// Input channel (in_valid / in_ready): one beat per event: func 0 is a pin
// edge with the level after it and the elapsed time in 128 us ticks, func 1
// is a timer overflow tick, func 2 polls for a decoded frame.
// Output channel (out_valid / out_ready): exactly one beat per input beat, in
// order: data_ready answers a poll (0 for every other item), address and
// command show the last latched good frame.
// Configuration channel (cfg_valid / cfg_ready, always ready): index 0 sets the
// overflow ticks before a timeout, indexes 1 to 4 the 256-bit repeat disable
// mask, 64 bits at a time; other indexes are ignored. Write only while idle.
// An accepted input beat is loaded into the input register; the decode step
// then runs on it and writes the decoder state and the result register
// together, once the result register has room.
// Throughput: one item per cycle while out_ready stays high; the decode logic is combinational.
// Reset clears the capture state, the latched frame and the channels, sets
// the timeout to 4 overflow ticks and clears the mask.
// When the receiver stalls, the result register holds and the input register
// still takes one more beat; after that in_ready drops until the output moves.
module nec_ir_frame_decoder import nif_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           func,
  input  logic                 level,
  input  logic [TICKS_W-1:0]   duration_ticks,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 data_ready,
  output logic [7:0]           address,
  output logic [7:0]           command,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  item_t   item_in, item;
  result_t res_next, res;
  logic    held, free, step;

  assign item_in   = '{func: func, level: level, duration_ticks: duration_ticks};
  assign step      = held && free;
  assign cfg_ready = 1'b1;

  // input register
  nif_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .item_in  (item_in),
    .step     (step),
    .held     (held),
    .item     (item)
  );

  // decode state machine and configuration
  nif_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (item),
    .result    (res_next)
  );

  // result register
  nif_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .result_in (res_next),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (res)
  );

  assign data_ready = res.data_ready;
  assign address    = res.address;
  assign command    = res.command;

endmodule

/* src/nif_checker.sv */
module nif_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       data_ready,
  input logic [7:0] address,
  input logic [7:0] command
);

  logic [7:0] last_addr;
  logic [7:0] last_cmd;

  // last address and command delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      last_addr <= '0;
      last_cmd  <= '0;
    end else if (out_valid && out_ready) begin
      last_addr <= address;
      last_cmd  <= command;
    end
  end

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_ready) && $stable(address)
      && $stable(command))
    else $error("stalled result beat changed");

  // the latched frame only moves on a successful poll
  a_latch_moves_on_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_ready |-> address == last_addr && command == last_cmd)
    else $error("address or command changed without data ready");

  // input side cannot fill while result side holds two items back
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !in_ready |=> !in_ready || $past(out_ready) || out_ready)
    else $error("input taken with the pipeline full");

endmodule

bind nec_ir_frame_decoder nif_checker u_nif_checker (.*);

/* dv/tb_nec_ir_frame_decoder.sv */
`timescale 1ns / 100ps

module tb_nec_ir_frame_decoder;
  import nif_pkg::*;

  // nominal NEC durations in us
  localparam int unsigned LEADER_US = 9500;
  localparam int unsigned START_US  = 4500;
  localparam int unsigned REPEAT_US = 2250;
  localparam int unsigned BIT_US    = 540;
  localparam int unsigned ONE_US    = 1688;

  localparam logic [1:0] FN_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int NUM_PHASES       = 6;
  localparam int RANDOM_PER_PHASE = 230;
  localparam int MAX_REPORTS      = 60;

  logic                 clk            = 1'b0;
  logic                 rst            = 1'b1;
  logic                 in_valid       = 1'b0;
  logic [1:0]           func           = FN_EDGE;
  logic                 level          = 1'b0;
  logic [TICKS_W-1:0]   duration_ticks = '0;
  logic                 out_ready      = 1'b0;
  logic                 cfg_valid      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = REG_TIMEOUT;
  logic [63:0]          cfg_data       = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 data_ready;
  logic [7:0]           address;
  logic [7:0]           command;
  logic                 cfg_ready;

  nec_ir_frame_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .level          (level),
    .duration_ticks (duration_ticks),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_ready     (data_ready),
    .address        (address),
    .command        (command),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #4 clk = ~clk;

  // decoder state as predicted
  phase_t       cap_phase;
  status_t      frm_status;
  logic [31:0]  rx_bits;
  logic [5:0]   rx_count;
  logic         rx_repeat;
  logic [7:0]   ovf_ticks;
  logic         ovf_armed;
  logic [7:0]   held_address;
  logic [7:0]   held_command;
  logic [7:0]   timeout_limit;
  logic [255:0] repeat_block;

  item_t   pending_items[$];
  result_t expected_results[$];
  int      items_queued    = 0;
  int      results_checked = 0;
  int      fail_count      = 0;
  int      reports         = 0;

  // frame builder state
  int edge_no    = 0;
  int spoil_at   = -1;
  int spoil_kind = 0;

  // sender and receiver pacing
  int          burst_left = 0;
  int          gap_left   = 0;
  item_t       next_item;
  result_t     want;
  logic [15:0] stall_pat  = 16'hFFFF;
  int          stall_step = 0;

  function automatic logic [7:0] tick_lo(int unsigned d);
    return 8'((d * 7 / 10 + TICK_US - 1) / TICK_US);
  endfunction

  function automatic logic [7:0] tick_hi(int unsigned d);
    return 8'((d * 13 / 10) / TICK_US);
  endfunction

  function automatic bit span_fits(int unsigned t, int unsigned d);
    return (t >= d * 7 / 10) && (t <= d * 13 / 10);
  endfunction

  // in-window tick count, leaning on the window edges
  function automatic logic [7:0] pick_ticks(int unsigned d);
    if (d == 0) return 8'($urandom);
    case ($urandom_range(0, 3))
      0: return tick_lo(d);
      1: return tick_hi(d);
      default: return 8'($urandom_range(tick_lo(d), tick_hi(d)));
    endcase
  endfunction

  // just outside the window on either side
  function automatic logic [7:0] near_miss(int unsigned d);
    if (d == 0) return 8'($urandom);
    if ($urandom_range(0, 1) == 1) return tick_hi(d) + 8'd1;
    return tick_lo(d) - 8'd1;
  endfunction

  function automatic void clear_decoder_model();
    cap_phase     = PH_IDLE;
    frm_status    = ST_NOT_READY;
    rx_bits       = '0;
    rx_count      = '0;
    rx_repeat     = 1'b0;
    ovf_ticks     = '0;
    ovf_armed     = 1'b0;
    held_address  = '0;
    held_command  = '0;
    timeout_limit = TIMEOUT_RST;
    repeat_block  = '0;
  endfunction

  function automatic void drop_capture();
    frm_status = ST_NOT_READY;
    cap_phase  = PH_IDLE;
  endfunction

  // one item through the decoder: update the predicted state, return the result
  function automatic result_t nec_decode_step(logic [1:0] f, logic lv, logic [7:0] tk);
    result_t     res;
    int unsigned t;
    logic [7:0]  a;
    logic [7:0]  c;
    res = '0;
    t   = TICK_US * tk;
    case (f)
      FN_EDGE: begin
        case (cap_phase)
          PH_IDLE: begin
            if (!lv) begin
              cap_phase = PH_LEAD;
              ovf_armed = 1'b1;
            end else begin
              frm_status = ST_NOT_READY;
            end
          end
          PH_LEAD: begin
            if (lv && span_fits(t, LEADER_US)) cap_phase = PH_LSPACE;
            else drop_capture();
          end
          PH_LSPACE: begin
            if (!lv && span_fits(t, START_US)) begin
              cap_phase = PH_DATA;
              rx_repeat = 1'b0;
              rx_count  = '0;
            end else if (!lv && span_fits(t, REPEAT_US)) begin
              cap_phase = PH_FINAL;
              rx_repeat = 1'b1;
            end else begin
              drop_capture();
            end
          end
          PH_DATA: begin
            // only the spaces carry data, pulse ends are ignored
            if (!lv) begin
              if (span_fits(t, BIT_US) || span_fits(t, ONE_US)) begin
                rx_bits[rx_count[4:0]] = span_fits(t, ONE_US);
                rx_count = rx_count + 6'd1;
                if (rx_count >= FRAME_BITS) cap_phase = PH_FINAL;
              end else begin
                drop_capture();
              end
            end
          end
          PH_FINAL: begin
            if (lv && span_fits(t, BIT_US)) begin
              if (!rx_repeat) frm_status = ST_READY;
              ovf_ticks = '0;
            end else begin
              frm_status = ST_NOT_READY;
            end
            cap_phase = PH_IDLE;
          end
          default: cap_phase = PH_IDLE;
        endcase
      end
      FN_OVF: begin
        if (ovf_armed) begin
          ovf_ticks = ovf_ticks + 8'd1;
          if (ovf_ticks >= timeout_limit) begin
            ovf_armed = 1'b0;
            drop_capture();
            ovf_ticks = '0;
          end
        end
      end
      FN_POLL: begin
        if (frm_status == ST_READY) begin
          a = rx_bits[7:0];
          c = rx_bits[23:16];
          if ((a ^ rx_bits[15:8]) != 8'hFF || (c ^ rx_bits[31:24]) != 8'hFF) begin
            frm_status = ST_NOT_READY;
          end else begin
            held_address = a;
            held_command = c;
            if (repeat_block[c]) frm_status = ST_NOT_READY;
            else frm_status = ST_REPEAT;
            res.data_ready = 1'b1;
          end
        end else begin
          res.data_ready = (frm_status == ST_REPEAT);
        end
      end
      default: ;
    endcase
    res.address = held_address;
    res.command = held_command;
    return res;
  endfunction

  task automatic queue_item(logic [1:0] f, logic lv, logic [7:0] tk);
    item_t it;
    it.func           = f;
    it.level          = lv;
    it.duration_ticks = tk;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // one edge of a frame, spoilt when its number comes up
  task automatic put_edge(logic lv, int unsigned d);
    if ($urandom_range(0, 49) == 0) queue_item(FN_OVF, 1'b0, 8'h00);
    if (edge_no != spoil_at) begin
      queue_item(FN_EDGE, lv, pick_ticks(d));
    end else begin
      case (spoil_kind)
        0: queue_item(FN_EDGE, ~lv, pick_ticks(d));
        1: queue_item(FN_EDGE, lv, near_miss(d));
        2: queue_item(FN_EDGE, lv, 8'($urandom));
        default: ;
      endcase
    end
    edge_no++;
  endtask

  // leader, start space, 32 bits lsb first, final pulse
  task automatic send_frame(logic [31:0] word, bit compact);
    edge_no = 0;
    put_edge(1'b0, 0);
    put_edge(1'b1, LEADER_US);
    put_edge(1'b0, START_US);
    for (int i = 0; i < FRAME_BITS; i++) begin
      if (!compact) put_edge(1'b1, BIT_US);
      put_edge(1'b0, word[i] ? ONE_US : BIT_US);
    end
    put_edge(1'b1, BIT_US);
  endtask

  task automatic send_repeat();
    edge_no = 0;
    put_edge(1'b0, 0);
    put_edge(1'b1, LEADER_US);
    put_edge(1'b0, REPEAT_US);
    put_edge(1'b1, BIT_US);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TIMEOUT: timeout_limit = val[7:0];
      REG_MASK_LO: repeat_block[63:0]    = val;
      REG_MASK_ML: repeat_block[127:64]  = val;
      REG_MASK_MH: repeat_block[191:128] = val;
      REG_MASK_HI: repeat_block[255:192] = val;
      default: ;
    endcase
  endtask

  // every queued item answered, then let the pipeline settle
  task automatic settle();
    wait (results_checked == items_queued);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(string what, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      fail_count++;
      if (reports < MAX_REPORTS)
        $display("%0t: %s expected %0h got %0h", $time, what, exp_v, got_v);
      reports++;
    end
  endtask

  // input beats: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(nec_decode_step(func, level, duration_ticks));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          func           <= next_item.func;
          level          <= next_item.level;
          duration_ticks <= next_item.duration_ticks;
          in_valid       <= 1'b1;
          if (burst_left > 1) begin
            burst_left = burst_left - 1;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result beats: compare with the oldest prediction, stall on a rotating pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (reports < MAX_REPORTS)
            $display("%0t: result beat with nothing expected, got %0h %0h %0h", $time,
                     data_ready, address, command);
          reports++;
        end else begin
          want = expected_results.pop_front();
          check_field("data_ready", want.data_ready, data_ready);
          check_field("address", want.address, address);
          check_field("command", want.command, command);
          results_checked++;
        end
      end
      if (stall_step == 0) stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      out_ready <= stall_pat[stall_step % 16];
      stall_step = (stall_step + 1) % 64;
    end
  end

  initial begin
    int unsigned target;
    int unsigned pick;
    int unsigned n;
    logic [7:0]  a8;
    logic [7:0]  c8;
    logic [7:0]  tmo;
    logic [31:0] word;
    logic [63:0] masks[4];
    bit          compact;

    clear_decoder_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) begin
        // directed: poll from reset, spare code, idle edges, timeout, repeat code
        queue_item(FN_POLL, 1'b0, 8'h00);
        queue_item(FN_SPARE, 1'b1, 8'hFF);
        queue_item(FN_OVF, 1'b1, 8'hFF);
        queue_item(FN_EDGE, 1'b1, 8'hFF);
        queue_item(FN_EDGE, 1'b0, 8'h00);
        queue_item(FN_EDGE, 1'b1, 8'hFF);
        repeat (4) queue_item(FN_OVF, 1'b0, 8'h00);
        queue_item(FN_EDGE, 1'b0, 8'h00);
        queue_item(FN_EDGE, 1'b1, tick_lo(LEADER_US));
        queue_item(FN_EDGE, 1'b0, tick_hi(REPEAT_US));
        queue_item(FN_EDGE, 1'b1, tick_lo(BIT_US));
        queue_item(FN_POLL, 1'b1, 8'hFF);
        // leader at its upper edge, pulse end in data ignored, then a bad space
        queue_item(FN_EDGE, 1'b0, 8'h80);
        queue_item(FN_EDGE, 1'b1, tick_hi(LEADER_US));
        queue_item(FN_EDGE, 1'b0, tick_lo(START_US));
        queue_item(FN_EDGE, 1'b1, 8'h00);
        queue_item(FN_EDGE, 1'b0, tick_hi(ONE_US));
        queue_item(FN_EDGE, 1'b0, 8'h7F);
        queue_item(FN_POLL, 1'b0, 8'h55);
        queue_item(FN_SPARE, 1'b0, 8'h2A);
      end else begin
        // quiet block: drain, then move to the next register setting
        settle();
        case (p)
          1: tmo = 8'd1;
          2: tmo = 8'hFF;
          3: tmo = 8'd0;
          4: tmo = 8'($urandom_range(2, 8));
          default: tmo = TIMEOUT_RST;
        endcase
        for (int r = 0; r < 4; r++) begin
          case (p)
            1: masks[r] = '1;
            2: masks[r] = '0;
            3: masks[r] = {$urandom, $urandom};
            4: masks[r] = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default: masks[r] = (r == 0) ? '1 : ((r == 2) ? '0 : {$urandom, $urandom});
          endcase
        end
        write_reg(REG_TIMEOUT, {$urandom, 24'($urandom), tmo});
        write_reg(REG_MASK_LO, masks[0]);
        write_reg(REG_MASK_ML, masks[1]);
        write_reg(REG_MASK_MH, masks[2]);
        write_reg(REG_MASK_HI, masks[3]);
        if (p % 2 == 1)
          write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), {$urandom, $urandom});
        cfg_valid <= 1'b0;
      end

      // random traffic, mostly well-formed frames and repeat codes
      target = items_queued + RANDOM_PER_PHASE;
      while (items_queued < target) begin
        pick    = $urandom_range(0, 99);
        compact = ($urandom_range(0, 2) != 0);
        a8      = 8'($urandom);
        c8      = 8'($urandom);
        word    = {~c8, c8, ~a8, a8};
        if ($urandom_range(0, 5) == 0) word[$urandom_range(0, 31)] ^= 1'b1;
        if (pick < 45) begin
          spoil_at = -1;
          send_frame(word, compact);
          if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) queue_item(FN_OVF, 1'($urandom), 8'($urandom));
          end
          n = $urandom_range(0, 3);
          repeat (n) queue_item(FN_POLL, 1'($urandom), 8'($urandom));
        end else if (pick < 62) begin
          spoil_at = -1;
          send_repeat();
          n = $urandom_range(1, 2);
          repeat (n) queue_item(FN_POLL, 1'($urandom), 8'($urandom));
        end else if (pick < 77) begin
          // broken sequence: one edge flipped, mistimed or missing
          spoil_kind = $urandom_range(0, 3);
          if ($urandom_range(0, 3) == 0) begin
            spoil_at = $urandom_range(0, 3);
            send_repeat();
          end else begin
            spoil_at = $urandom_range(0, compact ? 35 : 67);
            send_frame(word, compact);
          end
          n = $urandom_range(0, 1);
          repeat (n) queue_item(FN_POLL, 1'($urandom), 8'($urandom));
        end else if (pick < 88) begin
          n = $urandom_range(1, 6);
          repeat (n) queue_item(FN_OVF, 1'($urandom), 8'($urandom));
        end else begin
          n = $urandom_range(1, 4);
          repeat (n) queue_item(2'($urandom), 1'($urandom), 8'($urandom));
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("tb_nec_ir_frame_decoder passed");
    end else begin
      $display("tb_nec_ir_frame_decoder failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #4_000_000;
    $display("tb_nec_ir_frame_decoder failed");
    $finish;
  end

endmodule
